[rtl/mnp_pkg.sv]
// Shared types, character codes and lookup functions for the note parser.
package mnp_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_OCT,
		MODE_ACC,
		MODE_DUR,
		MODE_DOT,
		MODE_GSIGN,
		MODE_GLET
	} mnp_mode_t;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SHARP  = 8'h23;
	localparam logic [7:0] CH_FLAT   = 8'h40;
	localparam logic [7:0] CH_NAT    = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_REST   = 8'h50;
	localparam logic [7:0] CH_GROUP  = 8'h5B;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_D1     = 8'h31;
	localparam logic [7:0] CH_D2     = 8'h32;
	localparam logic [7:0] CH_D4     = 8'h34;
	localparam logic [7:0] CH_D8     = 8'h38;
	localparam logic [7:0] CH_D16    = 8'h36;

	localparam logic [4:0] UNIT_RESET = 5'd8;
	localparam logic [4:0] UNIT_MAX   = 5'd16;
	localparam logic [2:0] REG_UNIT_ADDR = 3'd0;
	localparam logic [9:0] DUR_MAX    = 10'd1023;

	typedef struct packed {
		logic       wr;
		logic [4:0] wr_eff;
		logic [4:0] eff;
	} mnp_cfg_t;

	typedef struct packed {
		logic              valid;
		logic              is_rest;
		logic signed [6:0] note;
		logic [9:0]        dur;
		logic              done;
	} mnp_event_t;

	function automatic logic [4:0] unit_eff(input logic [4:0] u);
		logic [4:0] r;
		r = u;
		if (u == 5'd0) begin
			r = 5'd1;
		end else if (u > UNIT_MAX) begin
			r = UNIT_MAX;
		end
		return r;
	endfunction

	function automatic logic signed [6:0] letter_base(input logic [2:0] idx);
		logic signed [6:0] r;
		case (idx)
			3'd0: r = 7'sd21;
			3'd1: r = 7'sd23;
			3'd2: r = 7'sd12;
			3'd3: r = 7'sd14;
			3'd4: r = 7'sd16;
			3'd5: r = 7'sd17;
			3'd6: r = 7'sd19;
			default: r = 7'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] dur_mult(input logic [7:0] c);
		logic [5:0] r;
		case (c)
			CH_D1:  r = 6'd32;
			CH_D2:  r = 6'd16;
			CH_D4:  r = 6'd8;
			CH_D8:  r = 6'd4;
			CH_D16: r = 6'd2;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/mnp_cfg.sv]
// Configuration register block holding the tick unit.
module mnp_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output mnp_pkg::mnp_cfg_t cfg
);
	import mnp_pkg::*;

	logic [4:0] unit_q;
	logic       hit;
	logic       wr_en;

	assign pready = 1'b1;
	assign hit    = (paddr == REG_UNIT_ADDR);
	assign wr_en  = psel & penable & pwrite & pready & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_RESET;
		end else if (wr_en) begin
			unit_q <= pwdata[4:0];
		end
	end

	assign prdata     = hit ? {27'd0, unit_q} : 32'd0;
	assign cfg.wr     = wr_en;
	assign cfg.wr_eff = unit_eff(pwdata[4:0]);
	assign cfg.eff    = unit_eff(unit_q);

endmodule

[rtl/mnp_core.sv]
// Parser state and the single-pass token logic for one character.
module mnp_core #(
	parameter int KEY_ENTRIES = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          char_code,
	input  logic                end_of_song,
	input  mnp_pkg::mnp_cfg_t   cfg,
	output mnp_pkg::mnp_event_t ev
);
	import mnp_pkg::*;

	mnp_mode_t         mode_q;
	logic signed [6:0] note_q;
	logic              rest_q;
	logic [2:0]        idx_q;
	logic signed [1:0] keys_q [KEY_ENTRIES];
	logic signed [1:0] sign_q;
	logic [9:0]        last_q;

	mnp_mode_t         mode_c;
	logic signed [6:0] note_c;
	logic              rest_c;
	logic [2:0]        idx_c;
	logic signed [1:0] keys_c [KEY_ENTRIES];
	logic signed [1:0] sign_c;
	logic [9:0]        last_c;
	logic              cons_c;
	logic [7:0]        ch;
	logic signed [1:0] key_k;
	logic signed [6:0] key_ext;
	logic [5:0]        mult;
	logic [10:0]       dur_ext;
	logic [2:0]        let_idx;
	logic              is_letter;

	assign ch        = end_of_song ? 8'd0 : char_code;
	assign is_letter = (ch >= CH_A) && (ch <= CH_G);
	assign let_idx   = 3'(ch - CH_A);
	assign mult      = dur_mult(ch);

	always_comb begin
		key_k = 2'sd0;
		for (int i = 0; i < KEY_ENTRIES; i++) begin
			if (idx_q == 3'(i)) begin
				key_k = keys_q[i];
			end
		end
	end
	assign key_ext = 7'({{5{key_k[1]}}, key_k});

	always_comb begin
		mode_c  = mode_q;
		note_c  = note_q;
		rest_c  = rest_q;
		idx_c   = idx_q;
		keys_c  = keys_q;
		sign_c  = sign_q;
		last_c  = last_q;
		cons_c  = 1'b0;
		dur_ext = 11'd0;
		ev      = '0;

		if (mode_c == MODE_OCT) begin
			if (ch == CH_PLUS) begin
				note_c = note_c + 7'sd12;
				cons_c = 1'b1;
			end else if (ch == CH_MINUS) begin
				note_c = note_c - 7'sd12;
				cons_c = 1'b1;
			end
			mode_c = MODE_ACC;
		end

		if (!cons_c && mode_c == MODE_ACC) begin
			note_c = note_c + key_ext;
			if (ch == CH_SHARP) begin
				if (key_k != 2'sd1) begin
					note_c = note_c + 7'sd1;
				end
				cons_c = 1'b1;
			end else if (ch == CH_FLAT) begin
				if (key_k != -2'sd1) begin
					note_c = note_c - 7'sd1;
				end
				cons_c = 1'b1;
			end else if (ch == CH_NAT) begin
				note_c = note_c - key_ext;
				cons_c = 1'b1;
			end
			mode_c = MODE_DUR;
		end

		if (!cons_c && mode_c == MODE_DUR) begin
			if (mult != 6'd0) begin
				last_c = 10'({5'd0, cfg.eff} * {4'd0, mult});
				cons_c = 1'b1;
			end
			mode_c = MODE_DOT;
		end

		if (!cons_c && mode_c == MODE_DOT) begin
			dur_ext = {1'b0, last_c};
			if (ch == CH_DOT) begin
				dur_ext = {1'b0, last_c} + {2'b0, last_c[9:1]};
				cons_c  = 1'b1;
			end
			ev.valid   = 1'b1;
			ev.is_rest = rest_c;
			ev.note    = rest_c ? 7'sd0 : note_c;
			ev.dur     = (dur_ext > {1'b0, DUR_MAX}) ? DUR_MAX : dur_ext[9:0];
			ev.done    = end_of_song;
			mode_c     = MODE_IDLE;
		end

		if (!cons_c) begin
			case (mode_c)
				MODE_GSIGN: begin
					if (ch == CH_SHARP) begin
						sign_c = 2'sd1;
						mode_c = MODE_GLET;
					end else if (ch == CH_FLAT) begin
						sign_c = -2'sd1;
						mode_c = MODE_GLET;
					end else begin
						mode_c = MODE_IDLE;
					end
				end
				MODE_GLET: begin
					if (is_letter) begin
						for (int i = 0; i < KEY_ENTRIES; i++) begin
							if (let_idx == 3'(i)) begin
								keys_c[i] = sign_c;
							end
						end
					end else begin
						mode_c = MODE_IDLE;
					end
				end
				default: begin
					if (is_letter) begin
						idx_c  = let_idx;
						note_c = letter_base(let_idx);
						rest_c = 1'b0;
						mode_c = MODE_OCT;
					end else if (ch == CH_REST) begin
						note_c = 7'sd0;
						rest_c = 1'b1;
						mode_c = MODE_DUR;
					end else if (ch == CH_GROUP) begin
						for (int i = 0; i < KEY_ENTRIES; i++) begin
							keys_c[i] = 2'sd0;
						end
						mode_c = MODE_GSIGN;
					end else begin
						mode_c = MODE_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			note_q <= 7'sd0;
			rest_q <= 1'b0;
			idx_q  <= 3'd0;
			sign_q <= 2'sd0;
			last_q <= {5'd0, UNIT_RESET};
			for (int i = 0; i < KEY_ENTRIES; i++) begin
				keys_q[i] <= 2'sd0;
			end
		end else if (cfg.wr) begin
			last_q <= {5'd0, cfg.wr_eff};
		end else if (step) begin
			if (end_of_song) begin
				mode_q <= MODE_IDLE;
				note_q <= 7'sd0;
				rest_q <= 1'b0;
				idx_q  <= 3'd0;
				sign_q <= 2'sd0;
				last_q <= {5'd0, cfg.eff};
				for (int i = 0; i < KEY_ENTRIES; i++) begin
					keys_q[i] <= 2'sd0;
				end
			end else begin
				mode_q <= mode_c;
				note_q <= note_c;
				rest_q <= rest_c;
				idx_q  <= idx_c;
				sign_q <= sign_c;
				last_q <= last_c;
				keys_q <= keys_c;
			end
		end
	end

endmodule

[rtl/music_notation_note_parser.sv]
// Top level: one song character per transfer in, one note or rest event out.
// A character is registered in the character register and its event in the result register.
// Throughput: one character per cycle while the output is not stalled; the character
// register and the result register let a new transfer in while a finished event waits.
// Reset clears the parser to idle, the key table to natural, the unit to 8.
module music_notation_note_parser #(
	parameter int KEY_ENTRIES = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] note, [16:7] duration_ticks, [23:17] zero
	output logic        m_tuser,   // [0] is_rest
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mnp_pkg::*;

	mnp_cfg_t   cfg;
	mnp_event_t ev;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              end_s1;
	logic              step;
	logic              out_valid_q;
	logic              out_rest_q;
	logic signed [6:0] out_note_q;
	logic [9:0]        out_dur_q;
	logic              out_done_q;

	mnp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	mnp_core #(
		.KEY_ENTRIES(KEY_ENTRIES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.char_code  (char_s1),
		.end_of_song(end_s1),
		.cfg        (cfg),
		.ev         (ev)
	);

	assign step     = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= ev.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ev.valid) begin
			out_rest_q <= ev.is_rest;
			out_note_q <= ev.note;
			out_dur_q  <= ev.dur;
			out_done_q <= ev.done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_dur_q, out_note_q};
	assign m_tuser  = out_rest_q;
	assign m_tlast  = out_done_q;

endmodule

[dv/tb_top.sv]
// Testbench for the note parser: random song text, a cycle-free predictor and in-order checks.
module tb_top;
	import mnp_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_LEN     = 300;
	localparam int PHASE_CHARS  = 220;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} song_char_t;

	typedef struct {
		logic              is_rest;
		logic signed [6:0] note;
		logic [9:0]        dur;
		logic              done;
	} note_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] char_code
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [6:0] note, [16:7] duration_ticks, [23:17] zero
	logic        m_tuser;          // [0] is_rest
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	song_char_t  char_q[$];
	note_event_t event_q[$];
	song_char_t  drv_char;
	note_event_t want;
	int          chars_put = 0;
	int          chars_taken = 0;
	int          chars_sent = 0;
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_go = 1'b0;
	int          hold_cnt = 0;

	// Predictor state.
	logic [4:0]  unit_reg;
	mnp_mode_t   pmode;
	int          pnote;
	logic        prest;
	int          let_idx;
	int          key_tab[7];
	int          grp_sign;
	int unsigned last_dur;
	int unsigned pdur;

	const int base_semi[7] = '{21, 23, 12, 14, 16, 17, 19};

	music_notation_note_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	function automatic int unsigned unit_clamped();
		if (unit_reg == 5'd0) return 1;
		if (unit_reg > 5'd16) return 16;
		return unit_reg;
	endfunction

	function automatic void clear_parser();
		pmode = MODE_IDLE;
		pnote = 0;
		prest = 1'b0;
		let_idx = 0;
		foreach (key_tab[i]) key_tab[i] = 0;
		grp_sign = 0;
		last_dur = unit_clamped();
		pdur = 0;
	endfunction

	// Advances the parser by one character and queues the event it completes, if any.
	function automatic void parse_char(input logic [7:0] ch_in, input logic eos);
		logic [7:0]  c;
		logic        took;
		logic        emit;
		int          k;
		int unsigned mult;
		note_event_t ev;
		c = eos ? 8'd0 : ch_in;
		took = 1'b0;
		emit = 1'b0;
		ev = '{1'b0, 7'sd0, 10'd0, 1'b0};
		for (int guard = 0; guard < 16 && !took; guard++) begin
			case (pmode)
				MODE_OCT: begin
					if (c == CH_PLUS) begin
						pnote += 12;
						took = 1'b1;
					end else if (c == CH_MINUS) begin
						pnote -= 12;
						took = 1'b1;
					end
					pmode = MODE_ACC;
				end
				MODE_ACC: begin
					k = key_tab[let_idx];
					pnote += k;
					if (c == CH_SHARP) begin
						if (k != 1) pnote += 1;
						took = 1'b1;
					end else if (c == CH_FLAT) begin
						if (k != -1) pnote -= 1;
						took = 1'b1;
					end else if (c == CH_NAT) begin
						pnote -= k;
						took = 1'b1;
					end
					pmode = MODE_DUR;
				end
				MODE_DUR: begin
					case (c)
						CH_D1:   mult = 32;
						CH_D2:   mult = 16;
						CH_D4:   mult = 8;
						CH_D8:   mult = 4;
						CH_D16:  mult = 2;
						default: mult = 0;
					endcase
					if (mult != 0) begin
						last_dur = unit_clamped() * mult;
						took = 1'b1;
					end
					pmode = MODE_DOT;
				end
				MODE_DOT: begin
					pdur = last_dur;
					if (c == CH_DOT) begin
						pdur = (pdur * 3) / 2;
						took = 1'b1;
					end
					if (pdur > 1023) pdur = 1023;
					emit = 1'b1;
					ev.is_rest = prest;
					ev.note = prest ? 7'sd0 : 7'(pnote);
					ev.dur = 10'(pdur);
					pmode = MODE_IDLE;
				end
				MODE_GSIGN: begin
					if (c == CH_SHARP) begin
						grp_sign = 1;
						pmode = MODE_GLET;
					end else if (c == CH_FLAT) begin
						grp_sign = -1;
						pmode = MODE_GLET;
					end else begin
						pmode = MODE_IDLE;
					end
					took = 1'b1;
				end
				MODE_GLET: begin
					if (c >= CH_A && c <= CH_G) begin
						key_tab[c - CH_A] = grp_sign;
					end else begin
						pmode = MODE_IDLE;
					end
					took = 1'b1;
				end
				default: begin
					if (c >= CH_A && c <= CH_G) begin
						let_idx = c - CH_A;
						pnote = base_semi[let_idx];
						prest = 1'b0;
						pmode = MODE_OCT;
					end else if (c == CH_REST) begin
						pnote = 0;
						prest = 1'b1;
						pmode = MODE_DUR;
					end else if (c == CH_GROUP) begin
						foreach (key_tab[i]) key_tab[i] = 0;
						pmode = MODE_GSIGN;
					end else begin
						pmode = MODE_IDLE;
					end
					took = 1'b1;
				end
			endcase
		end
		if (eos) clear_parser();
		if (emit) begin
			ev.done = eos;
			event_q.push_back(ev);
		end
	endfunction

	function automatic void put_char(input logic [7:0] ch, input logic eos);
		char_q.push_back('{ch, eos});
		chars_put++;
		chars_sent++;
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
	endfunction

	function automatic logic [7:0] pick_digit();
		case ($urandom_range(4))
			0: return CH_D1;
			1: return CH_D2;
			2: return CH_D4;
			3: return CH_D8;
			default: return CH_D16;
		endcase
	endfunction

	// One song: mostly well-formed notes, rests and key groups, with some noise.
	function automatic void gen_song();
		int ntok;
		int r;
		ntok = $urandom_range(1, 8);
		for (int t = 0; t < ntok; t++) begin
			r = $urandom_range(99);
			if (r < 60) begin
				put_char(CH_A + 8'($urandom_range(6)), 1'b0);
				if ($urandom_range(2) == 0) put_char($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
				case ($urandom_range(4))
					0: put_char(CH_SHARP, 1'b0);
					1: put_char(CH_FLAT, 1'b0);
					2: put_char(CH_NAT, 1'b0);
					default: ;
				endcase
				if ($urandom_range(2) != 0) put_char(pick_digit(), 1'b0);
				if ($urandom_range(3) == 0) put_char(CH_DOT, 1'b0);
			end else if (r < 72) begin
				put_char(CH_REST, 1'b0);
				if ($urandom_range(1)) put_char(pick_digit(), 1'b0);
				if ($urandom_range(3) == 0) put_char(CH_DOT, 1'b0);
			end else if (r < 84) begin
				put_char(CH_GROUP, 1'b0);
				case ($urandom_range(9))
					0: put_char(8'($urandom_range(255)), 1'b0);
					1, 2, 3, 4: put_char(CH_SHARP, 1'b0);
					default: put_char(CH_FLAT, 1'b0);
				endcase
				for (int j = $urandom_range(4); j > 0; j--) begin
					put_char(CH_A + 8'($urandom_range(6)), 1'b0);
				end
				put_char($urandom_range(1) ? 8'h5D : 8'($urandom_range(255)), 1'b0);
			end else begin
				put_char(8'($urandom_range(255)), 1'b0);
			end
		end
		if ($urandom_range(4) != 0) put_char(8'($urandom_range(255)), 1'b1);
	endfunction

	task automatic write_unit(input logic [4:0] u);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_UNIT_ADDR;
		pwdata <= {27'($urandom), u};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unit_reg = u;
		last_dur = unit_clamped();
	endtask

	task automatic drain();
		do @(posedge clk); while (chars_taken != chars_put || event_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idle(input int snd, input int rcv);
		@(posedge clk);
		send_idle_pct <= snd;
		recv_idle_pct <= rcv;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				parse_char(s_tdata, s_tlast);
				chars_taken++;
			end
			if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_char = char_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= drv_char.ch;
				s_tlast <= drv_char.eos;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go && hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (event_q.size() == 0) begin
					$error("unexpected event transfer: note %0d", $signed(m_tdata[6:0]));
					errors++;
				end else begin
					want = event_q.pop_front();
					if (m_tuser !== want.is_rest) begin
						$error("is_rest: expected %0d, got %0d", want.is_rest, m_tuser);
						errors++;
					end
					if (m_tdata[6:0] !== want.note) begin
						$error("note: expected %0d, got %0d", want.note, $signed(m_tdata[6:0]));
						errors++;
					end
					if (m_tdata[16:7] !== want.dur) begin
						$error("duration_ticks: expected %0d, got %0d", want.dur, m_tdata[16:7]);
						errors++;
					end
					if (m_tlast !== want.done) begin
						$error("song_done: expected %0d, got %0d", want.done, m_tlast);
						errors++;
					end
				end
			end
			m_tready <= !(hold_go && hold_cnt < HOLD_LEN) &&
				($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#(LIMIT_CYCLES * 20);
		$display("** music_notation_note_parser: FAILED **");
		$finish;
	end

	initial begin
		logic [4:0] units[6];
		units = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd8};
		unit_reg = UNIT_RESET;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		set_idle(32, 86);

		// Extremes of pitch, every accidental against the key table, dots and flushes.
		put_text("B+#1.C-@6P.[#CF;F#C$[@E]E@4");
		put_char(8'hFF, 1'b1);
		put_char(8'h00, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) set_idle(86, 32);
			if (ph == 4) set_idle(0, 0);
			write_unit(units[ph]);
			if (ph == 4) hold_go <= 1'b1;
			chars_sent = 0;
			while (chars_sent < PHASE_CHARS) gen_song();
			put_char(8'($urandom_range(255)), 1'b1);
			drain();
		end

		if (event_q.size() != 0) begin
			$error("%0d expected events never arrived", event_q.size());
			errors++;
		end
		if (errors == 0) begin
			$display("** music_notation_note_parser: PASSED **");
		end else begin
			$display("** music_notation_note_parser: FAILED **");
		end
		$finish;
	end

endmodule
